### rtl/spot_att_pkg.sv
// ----------------------------------------------------------------------------
// spot_att_pkg
// Item types, register indexes and fixed-point constants of the spotlight
// attenuation block.
// ----------------------------------------------------------------------------
package spot_att_pkg;

  localparam int WB = 30;
  localparam logic [31:0] ONE_Q30 = 32'd1 << WB;

  typedef struct packed {
    logic signed [15:0] ray_x;
    logic signed [15:0] ray_y;
    logic signed [15:0] ray_z;
  } spot_in_t;

  typedef struct packed {
    logic [16:0] attenuation;
    logic        lit;
  } spot_out_t;

  typedef enum logic [2:0] {
    REG_AXIS_X        = 3'd0,
    REG_AXIS_Y        = 3'd1,
    REG_AXIS_Z        = 3'd2,
    REG_CONE_EXPONENT = 3'd3,
    REG_COS_INNER     = 3'd4,
    REG_COS_OUTER     = 3'd5
  } cfg_reg_t;

  // falloff ramp selection
  typedef enum logic [2:0] {
    SM_ONE  = 3'b001,
    SM_ZERO = 3'b010,
    SM_DIV  = 3'b100
  } sm_mode_t;

  typedef logic [30:1][30:0] root_tab_t;

  function automatic logic [63:0] isqrt64(logic [63:0] a_in);
    logic [63:0] a;
    logic [63:0] root;
    logic [63:0] b;
    a    = a_in;
    root = '0;
    b    = 64'd1 << 62;
    while (b > a) b = b >> 2;
    while (b != 64'd0) begin
      if (a >= root + b) begin
        a    = a - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // 2^(-2^-i) in Q30, truncated square root chain from 0.5
  function automatic root_tab_t build_roots();
    root_tab_t   tab;
    logic [63:0] s;
    tab = '0;
    s   = 64'd1 << (WB - 1);
    for (int i = 1; i <= WB; i++) begin
      s      = isqrt64(s << WB);
      tab[i] = s[30:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOTS = build_roots();

endpackage

### rtl/spotlight_attenuation.sv
// ----------------------------------------------------------------------------
// spotlight_attenuation
// Spotlight cone attenuation: (-(ray . axis))^exponent times a smoothstep
// falloff between the outer and inner cone cosines, Q1.16 result.
// ----------------------------------------------------------------------------
// Usage:
//  - in_valid/in_stall/in_data carry one ray direction per item; the item is
//    taken at an edge with in_valid high and in_stall low.
//  - out_valid/out_stall/out_data return one result item per input item, in
//    order.
//  - cfg_we/cfg_idx/cfg_data write the six 16-bit registers; write only while
//    no item is in flight.
//  - One item is accepted every cycle while in_stall is low: the log2 loop
//    (32 squaring stages), the exp2 chain (30 multiply stages) and the
//    30-step ramp divider are all unrolled into pipeline stages, one
//    multiplier per stage.
//  - When out_stall holds a result, one more item parks in a skid register;
//    in_stall then rises and the whole pipeline freezes until it drains.
//  - rst_n (synchronous) empties the pipeline and loads register defaults
//    (exponent 1.0, axis and cosines 0).
// ----------------------------------------------------------------------------
module spotlight_attenuation #(
  parameter int VEC_FRAC_BITS = 15,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  spot_att_pkg::spot_in_t in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output spot_att_pkg::spot_out_t out_data,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_idx,
  input  logic [15:0]            cfg_data
);
  import spot_att_pkg::*;

  localparam int CW = (VEC_FRAC_BITS + 17 > 34) ? VEC_FRAC_BITS + 17 : 34;
  localparam int RW = (OUT_FRAC_BITS + 31 > 47) ? OUT_FRAC_BITS + 31 : 47;

  typedef struct packed {
    logic          v;
    logic          cpos;
    sm_mode_t      mode;
    logic [4:0]    p;
    logic [30:0]   x;
    logic [31:0]   f;
    logic [CW-1:0] rem;
    logic [CW-1:0] den;
    logic [30:0]   tq;
  } lst_t;

  typedef struct packed {
    logic        v;
    logic        cpos;
    logic        ypos;
    logic        nbig;
    logic [4:0]  n;
    logic [29:0] mf;
    logic [31:0] sm;
    logic [30:0] vv;
  } est_t;

  // configuration
  logic signed [15:0] axis_x_r, axis_y_r, axis_z_r, cos_inner_r, cos_outer_r;
  logic [15:0]        cone_exponent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_x_r        <= '0;
      axis_y_r        <= '0;
      axis_z_r        <= '0;
      cone_exponent_r <= 16'd256;
      cos_inner_r     <= '0;
      cos_outer_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_AXIS_X:        axis_x_r        <= cfg_data;
        REG_AXIS_Y:        axis_y_r        <= cfg_data;
        REG_AXIS_Z:        axis_z_r        <= cfg_data;
        REG_CONE_EXPONENT: cone_exponent_r <= cfg_data;
        REG_COS_INNER:     cos_inner_r     <= cfg_data;
        REG_COS_OUTER:     cos_outer_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic      en;
  logic      skid_v_r, out_v_r;
  spot_out_t skid_d_r, out_d_r;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // stage A: products
  logic               a_v_r;
  logic signed [31:0] a_p0_r, a_p1_r, a_p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_p0_r <= in_data.ray_x * axis_x_r;
      a_p1_r <= in_data.ray_y * axis_y_r;
      a_p2_r <= in_data.ray_z * axis_z_r;
    end
  end

  // stage B: c = -dot
  logic               b_v_r;
  logic signed [33:0] b_c_r, b_c_nxt;

  assign b_c_nxt = 34'sd0 - (34'(a_p0_r) + 34'(a_p1_r) + 34'(a_p2_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) b_c_r <= b_c_nxt;
  end

  // stage C: normalize for log2, ramp setup
  lst_t l_r [0:32];
  lst_t c_nxt;

  always_comb begin
    logic [31:0]          cu;
    logic [31:0]          sh;
    logic [4:0]           p;
    logic signed [CW-1:0] lo, hi, ce;
    cu = b_c_r[31:0];
    p  = '0;
    for (int j = 0; j < 32; j++) begin
      if (cu[j]) p = 5'(j);
    end
    sh = cu << (5'd31 - p);
    lo = CW'(cos_outer_r) <<< VEC_FRAC_BITS;
    hi = CW'(cos_inner_r) <<< VEC_FRAC_BITS;
    ce = CW'(b_c_r);
    c_nxt      = '0;
    c_nxt.v    = b_v_r;
    c_nxt.cpos = (b_c_r > 34'sd0);
    c_nxt.p    = p;
    c_nxt.x    = sh[31:1];
    c_nxt.rem  = CW'(ce - lo);
    c_nxt.den  = CW'(hi - lo);
    if (cos_inner_r <= 16'sd0)  c_nxt.mode = SM_ONE;
    else if (ce < lo)           c_nxt.mode = SM_ZERO;
    else if (ce > hi)           c_nxt.mode = SM_ONE;
    else if (hi == lo)          c_nxt.mode = SM_ZERO;
    else if (ce == hi)          c_nxt.mode = SM_ONE;
    else                        c_nxt.mode = SM_DIV;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) l_r[0] <= '0;
    else if (en) l_r[0] <= c_nxt;
  end

  // log2 squaring stages, ramp divider alongside
  for (genvar i = 1; i <= 32; i++) begin : g_log
    lst_t        l_nxt;
    logic [61:0] sq;
    logic [31:0] tsq;
    logic [CW:0] r2;
    logic        ge;

    always_comb begin
      sq    = l_r[i-1].x * l_r[i-1].x;
      tsq   = sq[61:30];
      r2    = {l_r[i-1].rem, 1'b0};
      ge    = (r2 >= {1'b0, l_r[i-1].den});
      l_nxt = l_r[i-1];
      l_nxt.x = tsq[31] ? tsq[31:1] : tsq[30:0];
      l_nxt.f = {l_r[i-1].f[30:0], tsq[31]};
      if (i <= WB) begin
        l_nxt.rem = ge ? CW'(r2 - {1'b0, l_r[i-1].den}) : CW'(r2);
        l_nxt.tq  = {l_r[i-1].tq[29:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) l_r[i] <= '0;
      else if (en) l_r[i] <= l_nxt;
    end
  end

  // stage Y: y = exponent * log2 c, t^2 and 3-2t
  logic               y_v_r, y_cpos_r;
  sm_mode_t           y_mode_r;
  logic signed [56:0] y_y_r, y_y_nxt;
  logic [29:0]        y_t2_r, y_t2_nxt;
  logic [31:0]        y_k_r, y_k_nxt;

  always_comb begin
    logic signed [7:0]  li;
    logic signed [39:0] logv;
    logic [61:0]        tt;
    li      = $signed({3'b000, l_r[32].p}) - 8'(2 * VEC_FRAC_BITS);
    logv    = {li, l_r[32].f};
    y_y_nxt = $signed({1'b0, cone_exponent_r}) * logv;
    tt      = l_r[32].tq * l_r[32].tq;
    y_t2_nxt = tt[59:30];
    y_k_nxt  = 32'(3 * ONE_Q30) - {l_r[32].tq, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_v_r <= 1'b0;
    end else if (en) begin
      y_v_r <= l_r[32].v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_cpos_r <= l_r[32].cpos;
      y_mode_r <= l_r[32].mode;
      y_y_r    <= y_y_nxt;
      y_t2_r   <= y_t2_nxt;
      y_k_r    <= y_k_nxt;
    end
  end

  // stage Z: exp2 setup and smoothstep product
  est_t e_r [0:30];
  est_t z_nxt;

  always_comb begin
    logic [56:0] m;
    logic [61:0] sp;
    m  = 57'(57'sd0 - y_y_r);
    sp = y_t2_r * y_k_r;
    z_nxt      = '0;
    z_nxt.v    = y_v_r;
    z_nxt.cpos = y_cpos_r;
    z_nxt.ypos = !y_y_r[56];
    z_nxt.nbig = (m[56:40] > 17'd30);
    z_nxt.n    = m[44:40];
    z_nxt.mf   = m[39:10];
    z_nxt.vv   = ONE_Q30[30:0];
    case (y_mode_r)
      SM_ONE:  z_nxt.sm = ONE_Q30;
      SM_ZERO: z_nxt.sm = '0;
      SM_DIV:  z_nxt.sm = sp[61:30];
      default: z_nxt.sm = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) e_r[0] <= '0;
    else if (en) e_r[0] <= z_nxt;
  end

  // exp2 chain: one root factor per stage
  for (genvar i = 1; i <= 30; i++) begin : g_exp
    est_t        e_nxt;
    logic [61:0] pr;

    always_comb begin
      pr    = e_r[i-1].vv * ROOTS[i];
      e_nxt = e_r[i-1];
      if (e_r[i-1].mf[30-i]) e_nxt.vv = pr[60:30];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) e_r[i] <= '0;
      else if (en) e_r[i] <= e_nxt;
    end
  end

  // stage F: integer part shift and saturation
  logic        f_v_r, f_cpos_r;
  logic [30:0] f_pw_r, f_pw_nxt;
  logic [31:0] f_sm_r;

  always_comb begin
    if (e_r[30].ypos)      f_pw_nxt = ONE_Q30[30:0];
    else if (e_r[30].nbig) f_pw_nxt = '0;
    else                   f_pw_nxt = e_r[30].vv >> e_r[30].n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= e_r[30].v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_cpos_r <= e_r[30].cpos;
      f_pw_r   <= f_pw_nxt;
      f_sm_r   <= e_r[30].sm;
    end
  end

  // stage G: power times ramp
  logic        g_v_r, g_cpos_r;
  logic [30:0] g_a_r;
  logic [62:0] g_prod;

  assign g_prod = f_pw_r * f_sm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (en) begin
      g_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_cpos_r <= f_cpos_r;
      g_a_r    <= g_prod[60:30];
    end
  end

  // stage H: round to output format
  logic          h_v_r;
  spot_out_t     h_d_r, h_d_nxt;
  logic [RW-1:0] h_sum;

  always_comb begin
    h_sum = (RW'(g_a_r) << OUT_FRAC_BITS) + RW'(ONE_Q30 >> 1);
    h_d_nxt.attenuation = g_cpos_r ? h_sum[46:30] : 17'd0;
    h_d_nxt.lit         = |h_d_nxt.attenuation;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
    end else if (en) begin
      h_v_r <= g_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) h_d_r <= h_d_nxt;
  end

  // output register and skid
  logic take;

  assign take = out_v_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (en) begin
      if (!out_v_r || take) begin
        out_v_r <= h_v_r;
      end else if (h_v_r) begin
        skid_v_r <= 1'b1;
      end
    end else if (take) begin
      skid_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!out_v_r || take) out_d_r <= h_d_r;
      else if (h_v_r)       skid_d_r <= h_d_r;
    end else if (take) begin
      out_d_r <= skid_d_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds an item while output register is empty");

  a_skid_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && out_stall && h_v_r))
    else $error("skid filled without a stalled output");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_stall) |=> (out_v_r && !skid_v_r))
    else $error("skid item not moved to output");

  a_lit_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_d_r.lit == (out_d_r.attenuation != 17'd0)))
    else $error("lit flag disagrees with attenuation");

endmodule

### tb/spotlight_attenuation_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spotlight_attenuation_checker
// Watches the ray and result channels and the register writes, computes the
// expected attenuation of every accepted ray and compares it in order.
// ----------------------------------------------------------------------------
module spotlight_attenuation_checker (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  spot_att_pkg::spot_in_t  in_data,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  spot_att_pkg::spot_out_t out_data,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_idx,
  input  logic [15:0]             cfg_data,
  output int                      fail_count,
  output int                      pending
);
  import spot_att_pkg::*;

  localparam logic [63:0] UNIT = 64'd1 << WB;

  logic signed [15:0] ax, ay, az, cin, cout;
  logic [15:0]        cexp;
  spot_out_t          att_queue[$];

  assign pending = att_queue.size();

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] a, r, b;
    a = v;
    r = 0;
    b = 64'd1 << 62;
    while (b > a) b >>= 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // log2 with 32 fraction bits; c carries 30 fraction bits
  function automatic longint cos_log2(logic [63:0] c);
    int          p;
    logic [63:0] x, f;
    p = 63;
    f = 0;
    while (p > 0 && c[p] == 1'b0) p--;
    x = (p >= WB) ? c >> (p - WB) : c << (WB - p);
    for (int i = 0; i < 32; i++) begin
      x = (x * x) >> WB;
      f = f << 1;
      if (x >= (UNIT << 1)) begin
        f[0] = 1'b1;
        x = x >> 1;
      end
    end
    return longint'(p - 30) * 64'sd4294967296 + longint'(f);
  endfunction

  function automatic logic [63:0] pow2_q30(longint y);
    logic [63:0] m, n, v, s;
    if (y >= 0) return UNIT;
    m = -y;
    n = m >> 40;
    if (n > WB) return 0;
    v = UNIT;
    s = UNIT >> 1;
    for (int i = 1; i <= WB; i++) begin
      s = int_sqrt(s << WB);
      if (m[40 - i]) v = (v * s) >> WB;
    end
    return v >> n;
  endfunction

  function automatic logic [63:0] falloff(longint c);
    longint      lo, hi;
    logic [63:0] num, den, rem, t, t2, k;
    lo = longint'(cout) * 32768;
    hi = longint'(cin) * 32768;
    t = 0;
    if (c < lo) return 0;
    if (c > hi) return UNIT;
    if (hi == lo) return 0;
    num = c - lo;
    den = hi - lo;
    if (num >= den) begin
      t = UNIT;
    end else begin
      rem = num;
      for (int i = 0; i < WB; i++) begin
        rem = rem << 1;
        t = t << 1;
        if (rem >= den) begin
          rem = rem - den;
          t[0] = 1'b1;
        end
      end
    end
    t2 = (t * t) >> WB;
    k = 3 * UNIT - 2 * t;
    return (t2 * k) >> WB;
  endfunction

  function automatic spot_out_t attenuate(spot_in_t r);
    longint      c;
    logic [63:0] pw, sm, a, att;
    spot_out_t   res;
    c = -(longint'(r.ray_x) * ax + longint'(r.ray_y) * ay + longint'(r.ray_z) * az);
    if (c <= 0) begin
      att = 0;
    end else begin
      pw = pow2_q30(longint'({48'd0, cexp}) * cos_log2(c));
      sm = (cin > 0) ? falloff(c) : UNIT;
      a = (pw * sm) >> WB;
      att = ((a << 16) + (UNIT >> 1)) >> WB;
    end
    res.attenuation = att[16:0];
    res.lit = (att[16:0] != 0);
    return res;
  endfunction

  always @(posedge clk) begin
    spot_out_t want;
    if (!rst_n) begin
      ax <= '0; ay <= '0; az <= '0; cexp <= 16'd256; cin <= '0; cout <= '0;
      fail_count <= 0;
      att_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_AXIS_X:        ax <= cfg_data;
          REG_AXIS_Y:        ay <= cfg_data;
          REG_AXIS_Z:        az <= cfg_data;
          REG_CONE_EXPONENT: cexp <= cfg_data;
          REG_COS_INNER:     cin <= cfg_data;
          REG_COS_OUTER:     cout <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) att_queue.push_back(attenuate(in_data));
      if (out_valid && !out_stall) begin
        if (att_queue.size() == 0) begin
          $display("%0t: unexpected result att=%0d lit=%0b", $time,
                   out_data.attenuation, out_data.lit);
          fail_count <= fail_count + 1;
        end else begin
          want = att_queue.pop_front();
          if (want.attenuation !== out_data.attenuation || want.lit !== out_data.lit) begin
            $display("%0t: mismatch expected att=%0d lit=%0b actual att=%0d lit=%0b",
                     $time, want.attenuation, want.lit, out_data.attenuation, out_data.lit);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### tb/spotlight_attenuation_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spotlight_attenuation_test
// Streams ray directions through the block under several spotlight settings
// with random gaps and output stalls; the checker compares every result.
// ----------------------------------------------------------------------------
module spotlight_attenuation_test;
  import spot_att_pkg::*;

  localparam int LATENCY = 70;
  localparam int HANG_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  spot_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  spot_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [15:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  bit          rx_stall_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  spotlight_attenuation DUT (.*);

  spotlight_attenuation_checker monitor (.*);

  // watchdog: cycles with nothing accepted
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("[spotlight_attenuation] ERROR");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (rx_stall_on && $urandom_range(0, 3) == 0) out_stall <= ($urandom_range(0, 9) < 8);
    else if (!rx_stall_on) out_stall <= 1'b0;
    else if ($urandom_range(0, 2) == 0) out_stall <= 1'b0;
  end

  // leaves in_valid high at the accepting edge; the next call or drain()
  // updates it in the same time step
  task automatic send_ray(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {x, y, z};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_light(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                           logic [15:0] e, logic [15:0] ci, logic [15:0] co);
    drain();
    write_reg(REG_AXIS_X, x);
    write_reg(REG_AXIS_Y, y);
    write_reg(REG_AXIS_Z, z);
    write_reg(REG_CONE_EXPONENT, e);
    write_reg(REG_COS_INNER, ci);
    write_reg(REG_COS_OUTER, co);
    cfg_we <= 1'b0;
  endtask

  // ray near the reversed axis, so c is mostly positive
  task automatic send_near(logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, int spread);
    send_ray(16'(-x + $urandom_range(0, 2 * spread) - spread),
             16'(-y + $urandom_range(0, 2 * spread) - spread),
             16'(-z + $urandom_range(0, 2 * spread) - spread));
  endtask

  initial begin
    logic [15:0] ax, ay, az, ex, ci, co;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset settings: zero axis, every ray is behind the light
    send_ray(16'h7fff, 16'h8000, 16'h0000);
    // axis +z, exponent 1, no ramp
    set_light(16'h0000, 16'h0000, 16'h7fff, 16'd256, 16'h0000, 16'h0000);
    send_ray(16'h0000, 16'h0000, 16'h8000);
    send_ray(16'h0000, 16'h0000, 16'h8001);
    send_ray(16'h0000, 16'h0000, 16'h7fff);
    send_ray(16'h0000, 16'h0000, 16'hffff);
    send_ray(16'h7fff, 16'h7fff, 16'hc000);
    send_ray(16'h8000, 16'h8000, 16'h8000);
    // zero exponent and largest exponent
    set_light(16'h0000, 16'h0000, 16'h7fff, 16'd0, 16'h0000, 16'h0000);
    send_ray(16'h0000, 16'h0000, 16'hffff);
    send_ray(16'h0000, 16'h0000, 16'hc000);
    set_light(16'h0000, 16'h0000, 16'h7fff, 16'hffff, 16'h0000, 16'h0000);
    send_ray(16'h0000, 16'h0000, 16'h8001);
    send_ray(16'h0000, 16'h0000, 16'h8000);
    send_ray(16'h0000, 16'h0000, 16'hff00);
    // ramp: inner 0.9, outer 0.5
    set_light(16'h0000, 16'h0000, 16'h8001, 16'd512, 16'd29491, 16'd16384);
    send_ray(16'h0000, 16'h0000, 16'd16384);
    send_ray(16'h0000, 16'h0000, 16'd20000);
    send_ray(16'h0000, 16'h0000, 16'd29491);
    send_ray(16'h0000, 16'h0000, 16'd32767);
    send_ray(16'h0000, 16'h0000, 16'd1000);
    // equal cones, and inner below outer
    set_light(16'h0000, 16'h0000, 16'h8000, 16'd256, 16'd20000, 16'd20000);
    send_ray(16'h0000, 16'h0000, 16'd20000);
    send_ray(16'h0000, 16'h0000, 16'd20001);
    set_light(16'h0000, 16'h0000, 16'h8000, 16'd256, 16'd10000, 16'd30000);
    send_ray(16'h0000, 16'h0000, 16'd20000);
    send_ray(16'h0000, 16'h0000, 16'd5000);
    send_ray(16'h0000, 16'h0000, 16'd31000);

    for (int phase = 0; phase < 10; phase++) begin
      rx_stall_on = (phase % 3 != 1);
      ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
      ex = 16'($urandom_range(0, 2048));
      if (phase == 9) ex = 16'($urandom);
      ci = 16'($urandom); co = 16'($urandom);
      if (phase % 2 == 0) begin
        ci = 16'($urandom_range(16000, 32767));
        co = 16'(ci - $urandom_range(0, 16000));
      end
      if (phase == 4) begin
        ax = 16'h8000; ay = 16'h7fff; az = 16'h8000; co = 16'h8000; ci = 16'h7fff;
      end
      set_light(ax, ay, az, ex, ci, co);
      for (int n = 0; n < 125; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          send_ray(16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
          send_near(ax, ay, az, ($urandom_range(0, 1) == 0) ? 2000 : 12000);
        end
      end
    end

    drain();
    if (fail_count == 0) $display("[spotlight_attenuation] OK");
    else $display("[spotlight_attenuation] ERROR");
    $finish;
  end

endmodule
